[sv/sett_pkg.sv]
// ----------------------------------------------------------------------------
// sett_pkg
// Shared types and codes for the scheduled event timer table.
// ----------------------------------------------------------------------------
package sett_pkg;

  localparam int unsigned TimeBits = 32;
  localparam int unsigned WordBits = 32;

  // Input item kind codes
  localparam logic KIND_SCHEDULE = 1'b0;
  localparam logic KIND_TICK     = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [WordBits-1:0] position_word;
    logic [TimeBits-1:0] time_value;
  } sett_in_t;

  typedef struct packed {
    logic [WordBits-1:0] fired_position;
    logic                fired_valid;
    logic                schedule_dropped;
    logic                last;
  } sett_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCHED,
    ST_SCAN,
    ST_FLUSH
  } sett_state_e;

endpackage

[sv/sett_mem.sv]
// ----------------------------------------------------------------------------
// sett_mem
// Slot storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sett_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned DW    = 64
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[sv/sett_alloc.sv]
// ----------------------------------------------------------------------------
// sett_alloc
// Lowest free slot finder over the active bits.
// ----------------------------------------------------------------------------
module sett_alloc #(
  parameter int unsigned SLOTS = 64,
  parameter int unsigned IW    = 6
) (
  input  logic [SLOTS-1:0] active_i,
  output logic [IW-1:0]    free_idx_o,
  output logic             full_o
);

  always_comb begin
    free_idx_o = '0;
    full_o     = 1'b1;
    // walk downward so the lowest free slot wins
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!active_i[i]) begin
        free_idx_o = IW'(i);
        full_o     = 1'b0;
      end
    end
  end

endmodule

[sv/scheduled_event_timer_table.sv]
// Schedule: the status result passes through ST_SCHED and the output register.
// Tick: every slot is read and compared, then ST_FLUSH pushes the last result.
// Throughput: one item in flight; a new item is taken only back in ST_IDLE.
//   The scan reads one slot per cycle unless a push meets a full output register.
//   Output stalls also hold ST_SCHED and ST_FLUSH.
// Reset clears all active bits at once; slot memory contents stay undefined.
// ----------------------------------------------------------------------------
// scheduled_event_timer_table
// Table of pending timed events held in a slot memory. Schedule fills the
// lowest free slot, else flags a drop; tick scans all slots and fires every due entry in order.
// ----------------------------------------------------------------------------
module scheduled_event_timer_table #(
  parameter int unsigned SLOT_COUNT    = 64,
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sett_pkg::sett_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sett_pkg::sett_out_t out_data_o
);

  import sett_pkg::*;

  localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CW = $clog2(SLOT_COUNT + 1);
  localparam int unsigned PW = POSITION_BITS;
  localparam int unsigned DW = TimeBits + PW;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  sett_state_e         state_q, state_d;
  logic [SLOT_COUNT-1:0] active_q, active_d;
  logic [TimeBits-1:0] tval_q, tval_d;      // current time of the tick in work
  logic                dropped_q, dropped_d;
  logic [CW-1:0]       cnt_q, cnt_d;        // next slot to read
  logic                s1_vld_q, s1_vld_d;  // read in flight, data in memory reg
  logic [IW-1:0]       s1_idx_q, s1_idx_d;
  logic                hold_vld_q, hold_vld_d; // fired result waiting for a successor
  logic [WordBits-1:0] hold_pos_q, hold_pos_d;
  logic                out_vld_q, out_vld_d;
  sett_out_t           out_q, out_d;

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  logic                in_acc;
  logic                out_free;
  logic [IW-1:0]       free_idx;
  logic                full;
  logic                mem_wr_en;
  logic [DW-1:0]       mem_wr_data;
  logic                mem_rd_en;
  logic [DW-1:0]       mem_rd_data;
  logic [PW-1:0]       wr_pos;
  logic [WordBits-1:0] rd_pos;
  logic [TimeBits-1:0] rd_due;
  logic                issue_pend;
  logic                fire;
  logic                stall1;
  logic                push;
  sett_out_t           push_data;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_vld_q || !out_stall_i;

  // stored position is POSITION_BITS wide; reported masked to 32 bits
  if (PW <= WordBits) begin : g_pos_narrow
    assign wr_pos = in_data_i.position_word[PW-1:0];
    if (PW == WordBits) begin : g_eq
      assign rd_pos = mem_rd_data[PW-1:0];
    end else begin : g_lt
      assign rd_pos = {{(WordBits - PW){1'b0}}, mem_rd_data[PW-1:0]};
    end
  end else begin : g_pos_wide
    assign wr_pos = {{(PW - WordBits){1'b0}}, in_data_i.position_word};
    assign rd_pos = mem_rd_data[WordBits-1:0];
  end

  assign rd_due      = mem_rd_data[DW-1:PW];
  assign mem_wr_data = {in_data_i.time_value, wr_pos};
  assign mem_wr_en   = in_acc && (in_data_i.kind == KIND_SCHEDULE) && !full;

  sett_alloc #(
    .SLOTS (SLOT_COUNT),
    .IW    (IW)
  ) u_alloc (
    .active_i   (active_q),
    .free_idx_o (free_idx),
    .full_o     (full)
  );

  sett_mem #(
    .DEPTH (SLOT_COUNT),
    .AW    (IW),
    .DW    (DW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (free_idx),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (cnt_q[IW-1:0]),
    .rd_data_o (mem_rd_data)
  );

  // Scan pipeline: slot read registered, then compared. A fired slot
  // replaces the held result, pushing the older one out with last clear; the
  // stage stalls only when that push meets a full output register.
  assign issue_pend = (cnt_q < CW'(SLOT_COUNT));
  assign fire       = (state_q == ST_SCAN) && s1_vld_q && active_q[s1_idx_q] &&
                      (rd_due <= tval_q);
  assign stall1     = fire && hold_vld_q && !out_free;
  assign mem_rd_en  = (state_q == ST_SCAN) && issue_pend && !stall1;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (in_data_i.kind == KIND_TICK) ? ST_SCAN : ST_SCHED;
        end
      end
      ST_SCHED: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (!issue_pend && !s1_vld_q) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs and datapath updates
  // --------------------------------------------------------------------------
  always_comb begin
    active_d   = active_q;
    tval_d     = tval_q;
    dropped_d  = dropped_q;
    cnt_d      = cnt_q;
    s1_vld_d   = s1_vld_q;
    s1_idx_d   = s1_idx_q;
    hold_vld_d = hold_vld_q;
    hold_pos_d = hold_pos_q;
    push       = 1'b0;
    push_data  = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.kind == KIND_SCHEDULE) begin
            dropped_d = full;
            if (!full) begin
              active_d[free_idx] = 1'b1;
            end
          end else begin
            tval_d     = in_data_i.time_value;
            cnt_d      = '0;
            s1_vld_d   = 1'b0;
            hold_vld_d = 1'b0;
          end
        end
      end
      ST_SCHED: begin
        push                       = out_free;
        push_data.schedule_dropped = dropped_q;
        push_data.last             = 1'b1;
      end
      ST_SCAN: begin
        if (!stall1) begin
          if (fire) begin
            active_d[s1_idx_q] = 1'b0;
            hold_vld_d         = 1'b1;
            hold_pos_d         = rd_pos;
            if (hold_vld_q) begin
              push                     = 1'b1;
              push_data.fired_position = hold_pos_q;
              push_data.fired_valid    = 1'b1;
            end
          end
          s1_vld_d = mem_rd_en;
          s1_idx_d = cnt_q[IW-1:0];
          if (mem_rd_en) begin
            cnt_d = cnt_q + CW'(1);
          end
        end
      end
      ST_FLUSH: begin
        push                     = out_free;
        push_data.fired_position = hold_vld_q ? hold_pos_q : '0;
        push_data.fired_valid    = hold_vld_q;
        push_data.last           = 1'b1;
        if (out_free) begin
          hold_vld_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // output register: loads on push, drains when taken
  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (push) begin
      out_vld_d = 1'b1;
      out_d     = push_data;
    end else if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      active_q   <= '0;
      cnt_q      <= '0;
      s1_vld_q   <= 1'b0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      active_q   <= active_d;
      cnt_q      <= cnt_d;
      s1_vld_q   <= s1_vld_d;
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tval_q     <= tval_d;
    dropped_q  <= dropped_d;
    s1_idx_q   <= s1_idx_d;
    hold_pos_q <= hold_pos_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
